FILE: rtl/vtdi_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// vtdi_pkg
// Shared constants and types for the vertex triple deduplication indexer.
// ============================================================================
package vtdi_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int INDEX_BITS  = 24;

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W   = 3 * INDEX_BITS;

  // Fixed field widths of the stream payloads.
  localparam int FIELD_W   = 24;
  localparam int CORNER_W  = 12;
  localparam int UNIQUE_W  = 13;
  localparam int RES_W     = CORNER_W + 1 + 1 + UNIQUE_W;
  localparam int S_TDATA_W = ((3 * FIELD_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

  // Bit positions inside the result word.
  localparam int RES_NEW_BIT  = CORNER_W;
  localparam int RES_FULL_BIT = CORNER_W + 1;
  localparam int RES_CNT_LSB  = CORNER_W + 2;

  typedef struct packed {
    logic [UNIQUE_W-1:0] unique_count;
    logic                table_full;
    logic                is_new;
    logic [CORNER_W-1:0] corner_index;
  } vtdi_result_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;
  } vtdi_ram_req_t;

endpackage

FILE: rtl/vtdi_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// vtdi_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module vtdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/vtdi_seq.sv
`timescale 1ns / 1ps
// ============================================================================
// vtdi_seq
// Search sequencer: walks the stored triples one per cycle through a single
// comparator, then appends, reports a match, or flags a full table.
// ============================================================================
module vtdi_seq import vtdi_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [KEY_W-1:0] in_key,
  input  logic          in_last,
  output logic          res_valid,
  input  logic          res_ready,
  output vtdi_result_t  res,
  output vtdi_ram_req_t ram_req,
  input  logic [KEY_W-1:0] ram_rd_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t              state;
  logic [KEY_W-1:0]    key;
  logic                last;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  issue_idx;
  logic                rd_pending;
  logic [ADDR_W-1:0]   rd_tag;
  logic                found;
  logic [ADDR_W-1:0]   match_idx;

  logic                hit;
  logic                scan_end;
  logic                can_issue;
  logic                is_new;
  logic [COUNT_W-1:0]  count_next;

  always_comb begin
    // The comparator sees the entry read in the previous cycle.
    hit       = rd_pending && (ram_rd_data == key);
    scan_end  = (issue_idx == count) && !rd_pending;
    can_issue = (state == S_SCAN) && !hit && (issue_idx < count);
    is_new    = !found && (count < COUNT_W'(TABLE_DEPTH));
    count_next = count + COUNT_W'(is_new);

    in_ready  = (state == S_IDLE);
    res_valid = (state == S_DONE);

    res.corner_index = found  ? CORNER_W'(match_idx) :
                       is_new ? CORNER_W'(count) : '0;
    res.is_new       = is_new;
    res.table_full   = !found && !is_new;
    res.unique_count = UNIQUE_W'(count_next);

    ram_req.rd_en   = can_issue;
    ram_req.rd_addr = issue_idx[ADDR_W-1:0];
    ram_req.wr_en   = (state == S_DONE) && res_ready && is_new;
    ram_req.wr_addr = count[ADDR_W-1:0];
    ram_req.wr_data = key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rd_pending <= 1'b0;
      found      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            key        <= in_key;
            last       <= in_last;
            issue_idx  <= '0;
            rd_pending <= 1'b0;
            found      <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pending <= can_issue;
          if (can_issue) begin
            rd_tag    <= issue_idx[ADDR_W-1:0];
            issue_idx <= issue_idx + COUNT_W'(1);
          end
          if (hit) begin
            found     <= 1'b1;
            match_idx <= rd_tag;
            state     <= S_DONE;
          end else if (scan_end) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            // The last corner of a shape empties the table for the next one.
            count <= last ? '0 : count_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/vertex_triple_dedup_indexer.sv
`timescale 1ns / 1ps
// ============================================================================
// vertex_triple_dedup_indexer
// Assigns output vertex indices to face corners, deduplicating their
// position/texture/normal index triples within one shape.
// ============================================================================
//
// Channel  Dir  Payload                                             Marker
// s_axis   in   pos_index, uv_index, normal_index (72 bits)         tlast = last_corner
// m_axis   out  corner_index, is_new, table_full, unique_count      none
//
// A corner is accepted, then its stored triples are read in turn through the
// single table read port, each registered before the comparator; the search
// then closes and the result is presented. A match ends the search early.
// Reset is synchronous; it empties the table by clearing the entry count.
// The result waits in an output register, so a stalled master side holds only
// the final step of the next corner.
module vertex_triple_dedup_indexer import vtdi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [23:0] pos_index, [47:24] uv_index, [71:48] normal_index
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [11:0] corner_index, [12] is_new, [13] table_full,
  // [26:14] unique_count, [31:27] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic             in_ready;
  logic [KEY_W-1:0] in_key;
  logic             res_valid;
  logic             res_ready;
  vtdi_result_t     res;
  vtdi_ram_req_t    ram_req;
  logic [KEY_W-1:0] ram_rd_data;

  // Only the low INDEX_BITS of each index take part in the match.
  assign in_key = {s_axis_tdata[2*FIELD_W +: INDEX_BITS],
                   s_axis_tdata[FIELD_W +: INDEX_BITS],
                   s_axis_tdata[0 +: INDEX_BITS]};

  assign s_axis_tready = in_ready;
  assign res_ready     = !m_axis_tvalid || m_axis_tready;

  vtdi_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (in_ready),
    .in_key      (in_key),
    .in_last     (s_axis_tlast),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  vtdi_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= M_TDATA_W'(res);
    end
  end

endmodule

FILE: rtl/vtdi_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// vtdi_checker
// Port-level checks for the vertex triple deduplication indexer.
// ============================================================================
module vtdi_checker import vtdi_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // A search keeps the input side busy in the cycle after the input transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on back-to-back cycles");

  a_new_full_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[RES_NEW_BIT] && m_axis_tdata[RES_FULL_BIT]))
    else $error("result is both new and full");

  a_full_index_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[RES_FULL_BIT] |->
      (m_axis_tdata[CORNER_W-1:0] == '0))
    else $error("full result carries a nonzero index");

  // An appended triple takes the index just below the new count.
  a_new_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[RES_NEW_BIT] |->
      (m_axis_tdata[RES_CNT_LSB +: UNIQUE_W] ==
       (UNIQUE_W'(m_axis_tdata[CORNER_W-1:0]) + UNIQUE_W'(1))))
    else $error("new entry index does not match the count");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind vertex_triple_dedup_indexer vtdi_checker u_vtdi_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the vertex triple deduplication indexer.
// Corners go in on the slave stream side and results come out on the master
// stream side, with random idle bursts on both sides. A scoreboard keeps its
// own table of the distinct triples in the current shape and checks each
// result field by field. The run covers directed corner cases and random
// shapes, and ends with a few shapes sent with no idling on either side.
// ============================================================================
module testbench;
  import vtdi_pkg::*;

  localparam longint CYCLE_LIMIT  = 200_000;
  localparam int     RANDOM_ITEMS = 100;
  localparam int     BIT_SEL_W    = $clog2(KEY_W);

  class corner_scoreboard;
    int unsigned  index_of [bit [KEY_W-1:0]];
    int unsigned  entries;
    vtdi_result_t expected_q [$];
    int unsigned  mismatches;

    function void note_mismatch(string field, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0d, got %0d", field, want, got);
    endfunction

    // Works out the result of one accepted corner and advances the shape table.
    function void note_corner(logic [KEY_W-1:0] triple, logic last);
      vtdi_result_t r;
      r = '0;
      if (index_of.exists(triple)) begin
        r.corner_index = CORNER_W'(index_of[triple]);
      end else if (entries < TABLE_DEPTH) begin
        index_of[triple] = entries;
        r.corner_index   = CORNER_W'(entries);
        r.is_new         = 1'b1;
        entries++;
      end else begin
        r.table_full = 1'b1;
      end
      r.unique_count = UNIQUE_W'(entries);
      expected_q.push_back(r);
      if (last) begin
        index_of.delete();
        entries = 0;
      end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] word);
      vtdi_result_t got;
      vtdi_result_t want;
      got = word[RES_W-1:0];
      if (expected_q.size() == 0) begin
        note_mismatch("unexpected result, corner_index", 0, got.corner_index);
        return;
      end
      want = expected_q.pop_front();
      if (got.corner_index !== want.corner_index)
        note_mismatch("corner_index", want.corner_index, got.corner_index);
      if (got.is_new !== want.is_new)
        note_mismatch("is_new", want.is_new, got.is_new);
      if (got.table_full !== want.table_full)
        note_mismatch("table_full", want.table_full, got.table_full);
      if (got.unique_count !== want.unique_count)
        note_mismatch("unique_count", want.unique_count, got.unique_count);
      if (word[M_TDATA_W-1:RES_W] !== '0)
        note_mismatch("padding", 0, word[M_TDATA_W-1:RES_W]);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  corner_scoreboard board;
  bit               quiet = 1'b0;
  longint           cycle_count = 0;

  vertex_triple_dedup_indexer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready)
      board.check_result(m_axis_tdata);
  end

  // Result side: random stall bursts until the final phase.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        m_axis_tready <= 1'b1;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        stall = $urandom_range(0, 6);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Triples are packed as {normal_index, uv_index, pos_index}.
  task automatic send_corner(input logic [KEY_W-1:0] triple, input logic last);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= S_TDATA_W'({$urandom, $urandom, $urandom});
      s_axis_tlast  <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= triple;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_corner(triple, last);
  endtask

  function automatic logic [INDEX_BITS-1:0] pick_index();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return INDEX_BITS'($urandom_range(1, 16));
      default: return INDEX_BITS'($urandom);
    endcase
  endfunction

  // One random shape: repeats, near misses that differ in one bit, and fresh
  // triples with absent, extreme or random indices.
  task automatic send_shape(input int shape_len);
    logic [KEY_W-1:0] pool [$];
    logic [KEY_W-1:0] triple;
    int               choice;
    for (int k = 0; k < shape_len; k++) begin
      choice = $urandom_range(0, 99);
      if (pool.size() != 0 && choice < 45) begin
        triple = pool[$urandom_range(0, pool.size() - 1)];
      end else if (pool.size() != 0 && choice < 60) begin
        triple = pool[$urandom_range(0, pool.size() - 1)];
        triple[BIT_SEL_W'($urandom_range(0, KEY_W - 1))] ^= 1'b1;
      end else begin
        triple = {pick_index(), pick_index(), pick_index()};
      end
      pool.push_back(triple);
      send_corner(triple, k == shape_len - 1);
    end
  endtask

  initial begin
    int sent;
    int shape_len;

    board         = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed corners: extremes, matches, single-field differences, last
    // corner on both a new and a matching triple, and a one-corner shape.
    send_corner({24'h000000, 24'h000000, 24'h000000}, 1'b0);
    send_corner({24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b0);
    send_corner({24'h000000, 24'h000000, 24'h000000}, 1'b0);
    send_corner({24'h000000, 24'h000000, 24'hFFFFFF}, 1'b0);
    send_corner({24'h000000, 24'hFFFFFF, 24'h000000}, 1'b0);
    send_corner({24'hFFFFFF, 24'h000000, 24'h000000}, 1'b0);
    send_corner({24'h000000, 24'h000000, 24'h000001}, 1'b0);
    send_corner({24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b0);
    send_corner({24'h000000, 24'h000000, 24'h000001}, 1'b0);
    send_corner({24'h000001, 24'h000001, 24'h000001}, 1'b1);
    send_corner({24'h000001, 24'h000001, 24'h000001}, 1'b0);
    send_corner({24'h000002, 24'h000002, 24'h000002}, 1'b0);
    send_corner({24'h000001, 24'h000001, 24'h000001}, 1'b1);
    send_corner({24'h000007, 24'h000000, 24'h000005}, 1'b1);
    send_corner({24'h000001, 24'h400000, 24'h800000}, 1'b0);
    send_corner({24'h000001, 24'h400000, 24'h800000}, 1'b1);
    send_corner({24'hAAAAAA, 24'h555555, 24'hAAAAAA}, 1'b0);
    send_corner({24'h555555, 24'hAAAAAA, 24'h555555}, 1'b0);
    send_corner({24'hAAAAAA, 24'h555555, 24'hAAAAAA}, 1'b1);

    // Random shapes of mostly short and sometimes longer length.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      shape_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                               : $urandom_range(1, 16);
      if (shape_len > RANDOM_ITEMS - sent)
        shape_len = RANDOM_ITEMS - sent;
      send_shape(shape_len);
      sent += shape_len;
    end

    // The closing shapes run with no idling on either side.
    quiet = 1'b1;
    send_shape(12);
    send_shape(8);

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
